/* design/mpa_pkg.sv */
// shared types and constants of the meter pulse accumulator
// used by mpa_arith, mpa_chan_mem and meter_pulse_accumulator; no dependencies
package mpa_pkg;

  // per-counter record kept in the channel memory
  typedef struct packed {
    logic [31:0] last_raw;
    logic [15:0] residue;
    logic [31:0] total;
    logic [31:0] period;
  } chan_rec_t;

  // operations of the shared arithmetic unit
  typedef logic [1:0] op_t;
  localparam op_t OP_ADD   = 2'd0;
  localparam op_t OP_SUB   = 2'd1;
  localparam op_t OP_MUL10 = 2'd2;

  localparam int ACC_W     = 33;   // residue plus difference, full width
  localparam int IN_W      = 64;   // 59 payload bits rounded up to bytes
  localparam int OUT_W     = 72;   // 70 payload bits rounded up to bytes
  localparam int DIV_STEPS = 33;   // one quotient bit per step
  localparam int STEP_W    = 6;

  localparam logic [3:0] FAIL_LIMIT = 4'd10;

endpackage

/* design/meter_pulse_accumulator.sv */
// meter pulse accumulator top level: sequencer, per-module error state, result word
// depends on mpa_pkg, mpa_arith and mpa_chan_mem
//
// One input word on s_* is one polled reading of one counter; one output word
// on m_* is returned for each reading, holding the addressed counter's total and
// period consumption after the update plus the module's error state.
// The block takes one word at a time: s_tready is high only while it is idle.
// m_tvalid rises in S_OUT, reached from S_LOAD when no counter is updated, via
// S_CMP and S_WRITE for a re-base, via S_CMP, S_SCALE and S_WRITE (S_ACC and
// S_DIV before S_SCALE for a divisor above 1) when the increment is zero, and on
// that path with one S_SCALE multiply per exponent unit, S_ADDT and S_ADDP for a
// counting update. The shared 33-bit arithmetic unit does one quotient bit per
// cycle in the restoring division, then one multiply-by-ten per cycle for the
// decimal scale. A new word can be taken the cycle after the result is accepted.
// A result is held on m_tdata until m_tready; no new word is taken meanwhile,
// so a stalled receiver stalls the sender after one word.
// Reset clears all counter records (through per-entry valid bits, no sweep),
// the error counts and flags, and returns the sequencer to idle at once.
module meter_pulse_accumulator #(
  parameter int MODULES             = 4,
  parameter int COUNTERS_PER_MODULE = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // module_index[1:0], counter_index[4:2], transfer_ok[5], has_counter_job[6],
  // raw_count[38:7], divisor[54:39], exponent[58:55], zero fill
  input  logic [mpa_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // total_count[31:0], period_count[63:32], counted[64], comm_error[65],
  // error_count[69:66], zero fill
  output logic [mpa_pkg::OUT_W-1:0]   m_tdata
);

  localparam int CHANNELS = MODULES * COUNTERS_PER_MODULE;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MOD_W    = (MODULES > 1) ? $clog2(MODULES) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SCALE = 4'd5;
  localparam logic [3:0] S_ADDT  = 4'd6;
  localparam logic [3:0] S_ADDP  = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // input word fields
  logic [1:0]  in_mod;
  logic [2:0]  in_cnt;
  logic        in_ok;
  logic        in_job;
  logic [31:0] in_raw;
  logic [15:0] in_div;
  logic [3:0]  in_exp;
  logic        in_mod_ok;
  logic        in_cnt_ok;
  logic [MOD_W-1:0] in_mod_idx;
  logic [CH_W-1:0]  in_ch;
  logic        accept;

  logic [3:0]  state;
  logic        mod_ok;
  logic        cnt_ok;
  logic        do_upd;
  logic [MOD_W-1:0] mod_idx;
  logic [CH_W-1:0]  ch;
  logic [31:0] raw;
  logic [15:0] div;
  logic [3:0]  expo;
  logic [31:0] last;
  logic [15:0] res;
  logic [31:0] tot;
  logic [31:0] per;
  logic [31:0] inc;
  logic [mpa_pkg::ACC_W-1:0]  dvd;
  logic [15:0] rem;
  logic [mpa_pkg::STEP_W-1:0] step;
  logic [3:0]  e_cnt;
  logic        counted;

  logic [3:0]  fail_count [MODULES];
  logic        fail_flag  [MODULES];

  // shared unit hookup
  mpa_pkg::op_t               op;
  logic [mpa_pkg::ACC_W-1:0]  op_a;
  logic [mpa_pkg::ACC_W-1:0]  op_b;
  logic [mpa_pkg::ACC_W-1:0]  op_y;
  logic                       op_borrow;

  logic [16:0] r_shift;
  logic        qbit;
  logic [mpa_pkg::ACC_W-1:0] dvd_next;

  mpa_pkg::chan_rec_t rd_data;
  mpa_pkg::chan_rec_t wr_data;
  logic               wr_en;

  assign in_mod = s_tdata[1:0];
  assign in_cnt = s_tdata[4:2];
  assign in_ok  = s_tdata[5];
  assign in_job = s_tdata[6];
  assign in_raw = s_tdata[38:7];
  assign in_div = s_tdata[54:39];
  assign in_exp = s_tdata[58:55];

  assign in_mod_ok  = int'(in_mod) < MODULES;
  assign in_cnt_ok  = int'(in_cnt) < COUNTERS_PER_MODULE;
  assign in_mod_idx = MOD_W'(in_mod);
  assign in_ch      = CH_W'(int'(in_mod) * COUNTERS_PER_MODULE + int'(in_cnt));

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  mpa_chan_mem #(
    .DEPTH  (CHANNELS),
    .ADDR_W (CH_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_mod_ok && in_cnt_ok),
    .rd_addr (in_ch),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ch),
    .wr_data (wr_data)
  );

  assign wr_en   = (state == S_WRITE);
  assign wr_data = '{last_raw: last, residue: res, total: tot, period: per};

  mpa_arith u_arith (
    .op     (op),
    .a      (op_a),
    .b      (op_b),
    .y      (op_y),
    .borrow (op_borrow)
  );

  // restoring division step: shift in the next dividend bit, try the subtract
  assign r_shift  = {rem, dvd[mpa_pkg::ACC_W-1]};
  assign qbit     = !op_borrow;
  assign dvd_next = {dvd[mpa_pkg::ACC_W-2:0], qbit};

  always_comb begin
    op   = mpa_pkg::OP_ADD;
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_CMP: begin
        op   = mpa_pkg::OP_SUB;
        op_a = {1'b0, raw};
        op_b = {1'b0, last};
      end
      S_ACC: begin
        op_a = {17'd0, res};
        op_b = {1'b0, inc};
      end
      S_DIV: begin
        op   = mpa_pkg::OP_SUB;
        op_a = {16'd0, r_shift};
        op_b = {17'd0, div};
      end
      S_SCALE: begin
        op   = mpa_pkg::OP_MUL10;
        op_a = {1'b0, inc};
      end
      S_ADDT: begin
        op_a = {1'b0, tot};
        op_b = {1'b0, inc};
      end
      S_ADDP: begin
        op_a = {1'b0, per};
        op_b = {1'b0, inc};
      end
      default: begin
        op   = mpa_pkg::OP_ADD;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= do_upd ? S_CMP : S_OUT;
        end
        S_CMP: begin
          if (last == 32'd0 || op_borrow) begin
            state <= S_WRITE;
          end else if (div > 16'd1) begin
            state <= S_ACC;
          end else begin
            state <= S_SCALE;
          end
        end
        S_ACC: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == mpa_pkg::STEP_W'(1)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (!counted) begin
            state <= S_WRITE;
          end else if (e_cnt == 4'd0) begin
            state <= S_ADDT;
          end
        end
        S_ADDT: begin
          state <= S_ADDP;
        end
        S_ADDP: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          mod_ok  <= in_mod_ok;
          cnt_ok  <= in_cnt_ok;
          do_upd  <= in_mod_ok && in_cnt_ok && in_ok && in_job;
          mod_idx <= in_mod_idx;
          ch      <= in_ch;
          raw     <= in_raw;
          div     <= in_div;
          expo    <= in_exp;
          counted <= 1'b0;
        end
      end
      S_LOAD: begin
        last <= rd_data.last_raw;
        res  <= rd_data.residue;
        tot  <= rd_data.total;
        per  <= rd_data.period;
      end
      S_CMP: begin
        last  <= raw;
        inc   <= op_y[31:0];
        e_cnt <= expo;
        // without prescaler the difference is the increment; a re-base counts nothing
        counted <= (last != 32'd0) && !op_borrow && (op_y[31:0] != 32'd0);
      end
      S_ACC: begin
        dvd  <= op_y;
        rem  <= 16'd0;
        step <= mpa_pkg::STEP_W'(mpa_pkg::DIV_STEPS);
      end
      S_DIV: begin
        dvd  <= dvd_next;
        rem  <= qbit ? op_y[15:0] : r_shift[15:0];
        step <= step - mpa_pkg::STEP_W'(1);
        if (step == mpa_pkg::STEP_W'(1)) begin
          res     <= qbit ? op_y[15:0] : r_shift[15:0];
          inc     <= dvd_next[31:0];
          counted <= (dvd_next != '0);
        end
      end
      S_SCALE: begin
        if (e_cnt != 4'd0) begin
          inc   <= op_y[31:0];
          e_cnt <= e_cnt - 4'd1;
        end
      end
      S_ADDT: begin
        tot <= op_y[31:0];
      end
      S_ADDP: begin
        per <= op_y[31:0];
      end
      default: begin
      end
    endcase
  end

  // per-module transfer error tracking, updated as the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MODULES; m++) begin
        fail_count[m] <= 4'd0;
        fail_flag[m]  <= 1'b0;
      end
    end else if (accept && in_mod_ok) begin
      if (in_ok) begin
        fail_count[in_mod_idx] <= 4'd0;
        fail_flag[in_mod_idx]  <= 1'b0;
      end else if (fail_count[in_mod_idx] > mpa_pkg::FAIL_LIMIT) begin
        fail_flag[in_mod_idx] <= 1'b1;
      end else begin
        fail_count[in_mod_idx] <= fail_count[in_mod_idx] + 4'd1;
      end
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {2'b00,
                     mod_ok ? fail_count[mod_idx] : 4'd0,
                     mod_ok && fail_flag[mod_idx],
                     mod_ok && cnt_ok && counted,
                     (mod_ok && cnt_ok) ? per : 32'd0,
                     (mod_ok && cnt_ok) ? tot : 32'd0};

  // never take a new word while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("sequencer did not leave idle after a word");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[69:66] <= 4'd11)
    else $error("error count beyond saturation");

  a_flag_saturated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[65] |-> m_tdata[69:66] == 4'd11)
    else $error("error flag set before the count saturated");

endmodule

/* design/mpa_arith.sv */
// shared 33-bit arithmetic unit: add, subtract with borrow, multiply by ten
// depends on mpa_pkg for the operation codes
module mpa_arith (
  input  mpa_pkg::op_t                 op,
  input  logic [mpa_pkg::ACC_W-1:0]    a,
  input  logic [mpa_pkg::ACC_W-1:0]    b,
  output logic [mpa_pkg::ACC_W-1:0]    y,
  output logic                         borrow
);

  logic [mpa_pkg::ACC_W-1:0] opa;
  logic [mpa_pkg::ACC_W-1:0] opb;
  logic                      cin;
  logic [mpa_pkg::ACC_W:0]   sum;

  always_comb begin
    opa = a;
    opb = b;
    cin = 1'b0;
    unique case (op)
      mpa_pkg::OP_ADD: begin
        opa = a;
        opb = b;
      end
      mpa_pkg::OP_SUB: begin
        opa = a;
        opb = ~b;
        cin = 1'b1;
      end
      mpa_pkg::OP_MUL10: begin
        // x*10 = x*8 + x*2
        opa = {a[mpa_pkg::ACC_W-4:0], 3'b000};
        opb = {a[mpa_pkg::ACC_W-2:0], 1'b0};
      end
      default: begin
        opa = a;
        opb = b;
      end
    endcase
  end

  assign sum    = {1'b0, opa} + {1'b0, opb} + {{mpa_pkg::ACC_W{1'b0}}, cin};
  assign y      = sum[mpa_pkg::ACC_W-1:0];
  assign borrow = (op == mpa_pkg::OP_SUB) && !sum[mpa_pkg::ACC_W];

endmodule

/* design/mpa_chan_mem.sv */
// per-counter record memory, one read and one write port, registered read
// entries never written read as zero through a valid bit each; uses mpa_pkg
module mpa_chan_mem #(
  parameter int DEPTH  = 24,
  parameter int ADDR_W = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output mpa_pkg::chan_rec_t  rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  mpa_pkg::chan_rec_t  wr_data
);

  mpa_pkg::chan_rec_t mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  mpa_pkg::chan_rec_t rd_raw;
  logic               rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule
